### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/smsd_pkg.sv
// types and constants for the sample mean and deviation block
package smsd_pkg;

  localparam int ACC_W      = 64;
  localparam int OUT_W      = 24;
  localparam int CNT_OUT_W  = 11;
  localparam int STEP_W     = 6;
  localparam int DIV_STEPS  = 64;
  localparam int SQRT_STEPS = 32;

  localparam logic [ACC_W-1:0] ACC_MAX  = {ACC_W{1'b1}};
  localparam logic [ACC_W-1:0] MAG_LIM  = 64'h0000_0000_FFFF_FFFF;
  localparam logic [ACC_W-1:0] SQRT_TOP = 64'h4000_0000_0000_0000;
  localparam logic [ACC_W-1:0] U24_MAX  = 64'h0000_0000_00FF_FFFF;
  localparam logic signed [ACC_W-1:0] S24_MAX = 64'sd8388607;
  localparam logic signed [ACC_W-1:0] S24_MIN = -64'sd8388608;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SETUP,
    S_MEAN,
    S_MEAN_FIX,
    S_RD,
    S_DIF,
    S_MUL,
    S_ACC,
    S_SD_SET,
    S_DIV,
    S_SQ_SET,
    S_SQRT,
    S_SE_SET,
    S_FIN
  } state_t;

endpackage

### rtl/core/sample_mean_and_std_deviation.sv
// sample mean, sample standard deviation and standard error of a stored set
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------------
//  request  | start / busy     | sample, last
//  result   | done (1 cycle)   | mean_value, std_deviation, std_error,
//           |                  | sample_count, single_sample, overflow
//
// a sample that is not last is only stored and summed; busy stays low, so the next can follow
// the last sample starts the computation: setup, mean divide, fix,
// then per stored sample memory read, difference, square, accumulate,
// then twice (setup, divide, setup, square root), then finish
// with one sample the pass, the two later divides and the roots are skipped
// rst is synchronous and clears the set; results cannot be held off by the receiver
module sample_mean_and_std_deviation
  import smsd_pkg::*;
#(
  parameter int STORE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic                   last,
  output logic                   busy,
  output logic                   done,
  output logic [OUT_W-1:0]       mean_value,
  output logic [OUT_W-1:0]       std_deviation,
  output logic [OUT_W-1:0]       std_error,
  output logic [CNT_OUT_W-1:0]   sample_count,
  output logic                   single_sample,
  output logic                   overflow
);

  localparam int AW   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CW   = $clog2(STORE_DEPTH + 1);
  localparam int SUMW = SAMPLE_BITS + CW;
  localparam int MW   = SAMPLE_BITS + 1;

  state_t state, state_next;

  // sample store
  logic [SAMPLE_BITS-1:0] mem [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rdata;

  // set state
  logic signed [SUMW-1:0] sum;
  logic [CW-1:0]          count;
  logic                   dropped;

  // shared datapath registers
  logic signed [SUMW-1:0] mean;
  logic                   neg;
  logic [ACC_W:0]         rem;
  logic [ACC_W-1:0]       quo;
  logic [ACC_W-1:0]       divisor;
  logic [STEP_W-1:0]      step;
  logic [CW-1:0]          idx;
  logic [MW-1:0]          mag;
  logic [ACC_W-1:0]       sq;
  logic [ACC_W-1:0]       sumsq;
  logic [ACC_W-1:0]       sv;
  logic [ACC_W-1:0]       res;
  logic [ACC_W-1:0]       bitr;
  logic [OUT_W-1:0]       sd;
  logic                   second;

  logic                   accept;
  logic                   room;
  logic [ACC_W:0]         trial;
  logic                   div_ge;
  logic [ACC_W-1:0]       sq_t;
  logic                   sq_ge;
  logic [ACC_W-1:0]       res_next;
  logic [SUMW-1:0]        abs_sum;
  logic signed [SUMW:0]   diff;
  logic [2*MW-1:0]        mag_sq;
  logic [ACC_W:0]         acc_sum;
  logic [CW-1:0]          cm1;
  logic [2*CW-1:0]        nn;
  logic signed [ACC_W-1:0] mean_w;
  logic                   last_idx;

  assign accept   = start && !busy;
  assign room     = count < CW'(STORE_DEPTH);
  assign abs_sum  = sum[SUMW-1] ? SUMW'(-sum) : SUMW'(sum);
  assign cm1      = count - CW'(1);
  assign nn       = (2*CW)'(cm1) * (2*CW)'(count);
  assign mean_w   = ACC_W'(mean);
  assign last_idx = (idx + CW'(1)) == count;

  // restore divider step, one quotient bit per cycle
  assign trial  = {rem[ACC_W-1:0], quo[ACC_W-1]};
  assign div_ge = trial >= {1'b0, divisor};

  // square root step, one result bit per cycle
  assign sq_t     = res + bitr;
  assign sq_ge    = sv >= sq_t;
  assign res_next = sq_ge ? ((res >> 1) + bitr) : (res >> 1);

  // deviation and square
  assign diff    = (SUMW+1)'($signed(rdata)) - (SUMW+1)'(mean);
  assign mag_sq  = (2*MW)'(mag) * (2*MW)'(mag);
  assign acc_sum = {1'b0, sumsq} + {1'b0, sq};

  // store write and registered read
  always_ff @(posedge clk) begin
    if (state == S_IDLE && accept && room) begin
      mem[count[AW-1:0]] <= sample;
    end
    rdata <= mem[idx[AW-1:0]];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and busy
  always_comb begin
    state_next = state;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE:     if (accept && last) state_next = S_SETUP;
      S_SETUP:    state_next = S_MEAN;
      S_MEAN:     if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_MEAN_FIX;
      S_MEAN_FIX: state_next = (count == CW'(1)) ? S_FIN : S_RD;
      S_RD:       state_next = S_DIF;
      S_DIF:      state_next = S_MUL;
      S_MUL:      state_next = S_ACC;
      S_ACC:      state_next = last_idx ? S_SD_SET : S_RD;
      S_SD_SET:   state_next = S_DIV;
      S_DIV:      if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_SQ_SET;
      S_SQ_SET:   state_next = S_SQRT;
      S_SQRT: begin
        if (step == STEP_W'(SQRT_STEPS - 1)) state_next = second ? S_FIN : S_SE_SET;
      end
      S_SE_SET:   state_next = S_DIV;
      S_FIN:      state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // set state and result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      count   <= '0;
      dropped <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == S_IDLE && accept) begin
        if (room) begin
          sum   <= sum + SUMW'($signed(sample));
          count <= count + CW'(1);
        end else begin
          dropped <= 1'b1;
        end
      end
      if (state == S_FIN) begin
        done    <= 1'b1;
        sum     <= '0;
        count   <= '0;
        dropped <= 1'b0;
      end
    end
  end

  // shared datapath
  always_ff @(posedge clk) begin
    case (state)
      S_SETUP: begin
        quo     <= ACC_W'(abs_sum);
        rem     <= '0;
        divisor <= ACC_W'(count);
        neg     <= sum[SUMW-1];
        step    <= '0;
      end
      S_MEAN, S_DIV: begin
        rem  <= div_ge ? (trial - {1'b0, divisor}) : trial;
        quo  <= {quo[ACC_W-2:0], div_ge};
        step <= step + STEP_W'(1);
      end
      S_MEAN_FIX: begin
        mean  <= neg ? SUMW'(-quo[SUMW-1:0]) : SUMW'(quo[SUMW-1:0]);
        idx   <= '0;
        sumsq <= '0;
      end
      S_DIF: begin
        mag <= diff[SUMW] ? MW'(-diff) : MW'(diff);
      end
      S_MUL: begin
        sq <= (ACC_W'(mag) > MAG_LIM) ? ACC_MAX : ACC_W'(mag_sq);
      end
      S_ACC: begin
        sumsq <= acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
        idx   <= idx + CW'(1);
      end
      S_SD_SET: begin
        quo     <= sumsq;
        rem     <= '0;
        divisor <= ACC_W'(cm1);
        step    <= '0;
        second  <= 1'b0;
      end
      S_SQ_SET: begin
        sv   <= quo;
        res  <= '0;
        bitr <= SQRT_TOP;
        step <= '0;
      end
      S_SQRT: begin
        if (sq_ge) sv <= sv - sq_t;
        res  <= res_next;
        bitr <= bitr >> 2;
        step <= step + STEP_W'(1);
      end
      S_SE_SET: begin
        sd      <= (res > U24_MAX) ? OUT_W'(U24_MAX) : res[OUT_W-1:0];
        quo     <= sumsq;
        rem     <= '0;
        divisor <= ACC_W'(nn);
        step    <= '0;
        second  <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (state == S_FIN) begin
      if (mean_w > S24_MAX) begin
        mean_value <= OUT_W'(S24_MAX);
      end else if (mean_w < S24_MIN) begin
        mean_value <= OUT_W'(S24_MIN);
      end else begin
        mean_value <= mean_w[OUT_W-1:0];
      end
      if (count == CW'(1)) begin
        std_deviation <= '0;
        std_error     <= '0;
      end else begin
        std_deviation <= sd;
        std_error     <= (res > U24_MAX) ? OUT_W'(U24_MAX) : res[OUT_W-1:0];
      end
      sample_count  <= CNT_OUT_W'(count);
      single_sample <= (count == CW'(1));
      overflow      <= dropped;
    end
  end

endmodule

### rtl/core/smsd_checker.sv
// port-level checks for the sample mean and deviation block, with its bind
`include "assert_macros.svh"

module smsd_checker
  import smsd_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 last,
  input logic                 busy,
  input logic                 done,
  input logic [OUT_W-1:0]     std_deviation,
  input logic [OUT_W-1:0]     std_error,
  input logic [CNT_OUT_W-1:0] sample_count,
  input logic                 single_sample
);

  // a result comes out only once the block is free again
  `ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "result while busy")

  // the result strobe is a single cycle
  `ASSERT_NEXT(a_done_pulse, clk, rst, done, !done, "result strobe longer than one cycle")

  // a last request starts the computation, any other request does not
  `ASSERT_NEXT(a_last_busy, clk, rst, start && !busy && last, busy && !done,
    "last request did not start the computation")
  `ASSERT_NEXT(a_plain_free, clk, rst, start && !busy && !last, !busy && !done,
    "plain request made the block busy")

  // one sample gives zero spread and a count of one
  `ASSERT_SAME(a_single, clk, rst, done && single_sample,
    std_deviation == '0 && std_error == '0 && sample_count == CNT_OUT_W'(1),
    "single sample result not zero")

endmodule

bind sample_mean_and_std_deviation smsd_checker u_smsd_checker (.*);

### tb/sv/tb_sample_mean_and_std_deviation.sv
// testbench for the sample mean and standard deviation block
`timescale 1ns / 100ps

module tb_sample_mean_and_std_deviation;
  import smsd_pkg::*;

  localparam int DEPTH = 1024;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [23:0] sample;
    logic        last;
  } request_t;

  typedef struct packed {
    logic [23:0] mean_value;
    logic [23:0] std_deviation;
    logic [23:0] std_error;
    logic [10:0] sample_count;
    logic        single_sample;
    logic        overflow;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [23:0] sample = '0;
  logic last = 1'b0;
  logic busy, done;
  logic [23:0] mean_value, std_deviation, std_error;
  logic [10:0] sample_count;
  logic single_sample, overflow;

  request_t pending_requests[$];
  stats_t   expected_stats[$];
  int       errors = 0;
  int       sets_done = 0;
  int       cycles = 0;
  bit       calm = 1'b0;

  // predictor copy of the set state
  longint set_store[DEPTH];
  longint set_sum = 0;
  int     set_count = 0;
  bit     set_dropped = 1'b0;

  sample_mean_and_std_deviation dut (
    .clk(clk), .rst(rst), .start(start), .sample(sample), .last(last),
    .busy(busy), .done(done), .mean_value(mean_value),
    .std_deviation(std_deviation), .std_error(std_error),
    .sample_count(sample_count), .single_sample(single_sample),
    .overflow(overflow)
  );

  always #5 clk = ~clk;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned root, bitv;
    root = 0;
    bitv = 64'h4000_0000_0000_0000;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // fold one request into the set, push the statistics when it closes the set
  function automatic void predict_stats(request_t req);
    longint x, mean, d;
    longint unsigned n, sumsq, mag, sq, sd, se;
    stats_t s;
    x = longint'(signed'(req.sample));
    if (set_count < DEPTH) begin
      set_store[set_count] = x;
      set_sum += x;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!req.last) return;
    n = set_count;
    mean = set_sum / longint'(n);
    sumsq = 0;
    sd = 0;
    se = 0;
    for (int i = 0; i < set_count; i++) begin
      d = set_store[i] - mean;
      mag = d < 0 ? -d : d;
      sq = mag > 64'hFFFF_FFFF ? '1 : mag * mag;
      sumsq = ('1 - sumsq < sq) ? '1 : sumsq + sq;
    end
    if (n > 1) begin
      sd = int_sqrt(sumsq / (n - 1));
      se = int_sqrt(sumsq / ((n - 1) * n));
      if (sd > 24'hFFFFFF) sd = 24'hFFFFFF;
      if (se > 24'hFFFFFF) se = 24'hFFFFFF;
    end
    if (mean > 8388607) mean = 8388607;
    if (mean < -8388608) mean = -8388608;
    s.mean_value = mean[23:0];
    s.std_deviation = sd[23:0];
    s.std_error = se[23:0];
    s.sample_count = n[10:0];
    s.single_sample = (n == 1);
    s.overflow = set_dropped;
    expected_stats.push_back(s);
    set_sum = 0;
    set_count = 0;
    set_dropped = 1'b0;
  endfunction

  function automatic logic [23:0] rand_sample(int kind);
    case (kind)
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'($urandom_range(0, 4095)) - 24'd2048;
      3: return 24'($urandom_range(0, 1 << 20)) + 24'h100000;
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic add_set(int len, int kind);
    request_t r;
    for (int i = 0; i < len; i++) begin
      r.sample = rand_sample(kind == 9 ? $urandom_range(0, 4) : kind);
      r.last = (i == len - 1);
      pending_requests.push_back(r);
    end
  endtask

  // driver: presents the head request, drops it once accepted
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) void'(pending_requests.pop_front());
      if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
        request_t nxt;
        nxt = pending_requests[0];
        start <= 1'b1;
        sample <= nxt.sample;
        last <= nxt.last;
      end else if (pending_requests.size() == 0 || !(start && busy)) begin
        start <= 1'b0;
      end
    end
  end

  // predictor runs on each accepted request
  always @(posedge clk) begin
    if (!rst && start && !busy) predict_stats('{sample, last});
  end

  // monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (expected_stats.size() == 0) begin
        $error("result with no expectation waiting");
        errors++;
      end else begin
        stats_t e;
        e = expected_stats.pop_front();
        sets_done <= sets_done + 1;
        if (mean_value !== e.mean_value) begin
          $error("mean_value exp %h got %h", e.mean_value, mean_value); errors++;
        end
        if (std_deviation !== e.std_deviation) begin
          $error("std_deviation exp %h got %h", e.std_deviation, std_deviation);
          errors++;
        end
        if (std_error !== e.std_error) begin
          $error("std_error exp %h got %h", e.std_error, std_error); errors++;
        end
        if (sample_count !== e.sample_count) begin
          $error("sample_count exp %0d got %0d", e.sample_count, sample_count);
          errors++;
        end
        if (single_sample !== e.single_sample) begin
          $error("single_sample exp %b got %b", e.single_sample, single_sample);
          errors++;
        end
        if (overflow !== e.overflow) begin
          $error("overflow exp %b got %b", e.overflow, overflow); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int total;
    // directed: extremes, single sample, overflow of the store
    add_set(1, 0);
    add_set(1, 1);
    add_set(2, 0);
    add_set(2, 1);
    add_set(3, 9);
    add_set(4, 2);
    add_set(5, 3);
    add_set(DEPTH + 3, 9);
    total = DEPTH + 21;
    // random short sets
    while (total < 1900) begin
      int len;
      len = $urandom_range(1, 24);
      add_set(len, $urandom_range(0, 9) < 5 ? 9 : $urandom_range(0, 4));
      total += len;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    // stretch without random request gaps partway through
    fork
      begin
        repeat (5000) @(posedge clk);
        calm = 1'b1;
        repeat (20000) @(posedge clk);
        calm = 1'b0;
      end
    join_none
    wait (pending_requests.size() == 0);
    @(posedge clk);
    wait (expected_stats.size() == 0);
    repeat (20) @(posedge clk);
    $display("ran %0d statistics sets with extremes, single samples and full stores",
             sets_done);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/smsd_pkg.sv
rtl/core/sample_mean_and_std_deviation.sv
rtl/core/smsd_checker.sv
tb/sv/tb_sample_mean_and_std_deviation.sv
